@@ design/uiv_pkg.sv @@
// Shared types and constants for the UTF-8 identifier validator.
package uiv_pkg;

	localparam int unsigned MAX_ID_BYTES_DEF = 256;
	localparam int unsigned CFG_W            = 9;
	localparam int unsigned LEN_W            = 9;
	localparam int unsigned ACC_W            = 21;
	localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 9'd256;

	// lead byte ranges
	localparam logic [7:0] ASCII_MAX  = 8'h7f;
	localparam logic [7:0] LEAD2_MIN  = 8'hc2;
	localparam logic [7:0] LEAD2_MAX  = 8'hdf;
	localparam logic [7:0] LEAD3_MIN  = 8'he0;
	localparam logic [7:0] LEAD3_MAX  = 8'hef;
	localparam logic [7:0] LEAD4_MIN  = 8'hf0;
	localparam logic [7:0] LEAD4_MAX  = 8'hf4;
	localparam logic [7:0] CONT_MASK  = 8'hc0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	// code point limits
	localparam logic [ACC_W-1:0] CP_MIN3    = 21'h000800;
	localparam logic [ACC_W-1:0] CP_MIN4    = 21'h010000;
	localparam logic [ACC_W-1:0] CP_SURR_LO = 21'h00d800;
	localparam logic [ACC_W-1:0] CP_SURR_HI = 21'h00dfff;
	localparam logic [ACC_W-1:0] CP_MAX     = 21'h10ffff;

	// sequence kinds
	localparam logic [1:0] KIND_1B = 2'd0;
	localparam logic [1:0] KIND_2B = 2'd1;
	localparam logic [1:0] KIND_3B = 2'd2;
	localparam logic [1:0] KIND_4B = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
		logic       empty_string;
	} in_t;

	typedef struct packed {
		logic             id_valid;
		logic [LEN_W-1:0] length_seen;
	} out_t;

	typedef struct packed {
		logic [1:0]       pend;
		logic [1:0]       kind;
		logic [ACC_W-1:0] acc;
		logic             err;
	} dec_state_t;

endpackage

@@ design/utf8_identifier_validator_core.sv @@
// Top level of the strict UTF-8 identifier validator.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | sink      | in_valid / in_ready | in_data  (uiv_pkg::in_t)
//  out     | source    | out_valid/out_ready | out_data (uiv_pkg::out_t)
//  cfg     | sink      | cfg_we              | cfg_data (max_length, 9 bits)
//
// One byte per cycle while in_ready is high: a transfer updates the decoder
// state in the same cycle, one decode step of logic between the state registers
// and the result register. Only the item that ends a string loads the result
// register, valid from the cycle after its transfer. in_ready drops only while
// a result sits in out_data and out_ready is low. arst_n clears the decoder
// state, byte count and result valid; max_length resets to 256.
module utf8_identifier_validator_core #(
	parameter int unsigned MAX_ID_BYTES = uiv_pkg::MAX_ID_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  uiv_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output uiv_pkg::out_t              out_data,
	input  logic                       cfg_we,
	input  logic [uiv_pkg::CFG_W-1:0]  cfg_data
);
	import uiv_pkg::*;

	// count saturates at MAX_ID_BYTES+1
	localparam int unsigned CNT_W = $clog2(MAX_ID_BYTES + 2);
	localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_ID_BYTES + 1);
	localparam logic [CMP_W-1:0] LIM_MAX = CMP_W'(MAX_ID_BYTES);

	logic [CFG_W-1:0] max_length_q;
	dec_state_t       st_q, st_dec, st_take;
	logic [CNT_W-1:0] cnt_q, cnt_take;
	logic             out_valid_q;
	out_t             out_data_q;

	logic             xfer, ends, take;
	logic [CMP_W-1:0] limit;
	logic             ok;

	uiv_decode u_dec (
		.cur       (st_q),
		.data_byte (in_data.data_byte),
		.nxt       (st_dec)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign xfer     = in_valid && in_ready;
	assign take     = !in_data.empty_string;
	assign ends     = in_data.end_of_string || in_data.empty_string;

	// state after absorbing this item's byte, if any
	assign st_take  = take ? st_dec : st_q;
	assign cnt_take = (take && cnt_q < CNT_SAT) ? cnt_q + CNT_W'(1) : cnt_q;

	// limit clamps to the parameter maximum
	assign limit = (CMP_W'(max_length_q) > LIM_MAX) ? LIM_MAX : CMP_W'(max_length_q);
	assign ok    = !st_take.err && st_take.pend == 2'd0 &&
	               cnt_take != '0 && CMP_W'(cnt_take) <= limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			max_length_q <= cfg_data;
		end
	end

	// string state: cleared after every ending item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= '0;
		end else if (xfer) begin
			if (ends) begin
				st_q  <= '0;
				cnt_q <= '0;
			end else begin
				st_q  <= st_take;
				cnt_q <= cnt_take;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer && ends) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (xfer && ends) begin
			out_data_q.id_valid    <= ok;
			out_data_q.length_seen <= LEN_W'(cnt_take);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ design/uiv_decode.sv @@
// One-byte step of the strict UTF-8 decoder state.
module uiv_decode (
	input  uiv_pkg::dec_state_t cur,
	input  logic [7:0]          data_byte,
	output uiv_pkg::dec_state_t nxt
);
	import uiv_pkg::*;

	logic [ACC_W-1:0] acc_shift;
	logic             is_cont;

	assign acc_shift = {cur.acc[ACC_W-7:0], data_byte[5:0]};
	assign is_cont   = (data_byte & CONT_MASK) == CONT_TAG;

	always_comb begin
		nxt = cur;
		if (cur.pend == 2'd0) begin
			priority if (data_byte <= ASCII_MAX) begin
				nxt.acc  = ACC_W'(data_byte);
				nxt.kind = KIND_1B;
			end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
				nxt.acc  = ACC_W'(data_byte[4:0]);
				nxt.pend = 2'd1;
				nxt.kind = KIND_2B;
			end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
				nxt.acc  = ACC_W'(data_byte[3:0]);
				nxt.pend = 2'd2;
				nxt.kind = KIND_3B;
			end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
				nxt.acc  = ACC_W'(data_byte[2:0]);
				nxt.pend = 2'd3;
				nxt.kind = KIND_4B;
			end else begin
				nxt.err = 1'b1;
			end
		end else if (!is_cont) begin
			nxt.err  = 1'b1;
			nxt.pend = 2'd0;
			nxt.kind = KIND_1B;
		end else begin
			nxt.acc  = acc_shift;
			nxt.pend = cur.pend - 2'd1;
			if (cur.pend == 2'd1) begin
				// sequence complete: overlong, surrogate and range checks
				if ((cur.kind == KIND_3B && acc_shift < CP_MIN3) ||
				    (cur.kind == KIND_4B && acc_shift < CP_MIN4) ||
				    (acc_shift >= CP_SURR_LO && acc_shift <= CP_SURR_HI) ||
				    acc_shift > CP_MAX)
					nxt.err = 1'b1;
				nxt.kind = KIND_1B;
			end
		end
	end

endmodule

@@ design/uiv_checker.sv @@
// Port-level assertions for the validator core, bound to the top level.
module uiv_checker #(
	parameter int unsigned MAX_ID_BYTES = uiv_pkg::MAX_ID_BYTES_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input uiv_pkg::in_t              in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input uiv_pkg::out_t             out_data
);
	import uiv_pkg::*;

	localparam logic [LEN_W:0] LEN_CAP = (MAX_ID_BYTES + 1 > 511) ? 10'd511
	                                     : (LEN_W + 1)'(MAX_ID_BYTES + 1);

	logic end_xfer;
	assign end_xfer = in_valid && in_ready &&
	                  (in_data.end_of_string || in_data.empty_string);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// new result only after a string-ending transfer
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(end_xfer))
		else $error("result without ending transfer");

	// full stalled result register blocks input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// empty string never valid; count never exceeds saturation
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.length_seen != '0) || !out_data.id_valid) &&
		              ({1'b0, out_data.length_seen} <= LEN_CAP))
		else $error("bad length or validity");

endmodule

bind utf8_identifier_validator_core uiv_checker #(.MAX_ID_BYTES(MAX_ID_BYTES)) u_uiv_chk (.*);

@@ bench/utf8_identifier_validator_core_test.sv @@
// Testbench for utf8_identifier_validator_core: streams identifier bytes and checks every verdict.
`timescale 1ns / 1ps

module utf8_identifier_validator_core_test;
	import uiv_pkg::*;

	localparam int unsigned ID_MAX        = MAX_ID_BYTES_DEF;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          RANDOM_PHASES = 6;
	localparam int          PHASE_ITEMS   = 40;

	// how the last item of a string is formed
	typedef enum logic [1:0] {
		END_ON_BYTE,     // last byte carries end_of_string
		END_EMPTY_MARK,  // trailing empty marker with end_of_string set
		END_EMPTY_BARE   // trailing empty marker with end_of_string clear
	} closing_t;

	typedef logic [7:0] byte_q_t[$];

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_t        in_data;
	logic       out_valid;
	logic       out_ready;
	out_t       out_data;
	logic       cfg_we;
	logic [CFG_W-1:0] cfg_data;

	utf8_identifier_validator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Verdict predictor: its own copy of the decoder state and the limit.
	// ------------------------------------------------------------------
	logic [1:0]       pend_cont  = 2'd0;
	logic [1:0]       seq_kind   = KIND_1B;
	logic [ACC_W-1:0] cp_acc     = '0;
	logic             fault_seen = 1'b0;
	int unsigned      byte_tally = 0;
	logic [CFG_W-1:0] limit_reg  = MAX_LENGTH_RST;

	out_t expected_verdicts[$];
	int   mismatches  = 0;
	int   items_sent  = 0;
	bit   tx_quiet    = 1'b0;
	bit   rx_quiet    = 1'b0;
	bit   hold_off_req = 1'b0;

	function automatic void absorb_byte(input logic [7:0] b);
		logic [ACC_W-1:0] cp;
		if (byte_tally < ID_MAX + 1)
			byte_tally++;
		if (pend_cont == 2'd0) begin
			// expecting a lead byte
			if (b <= ASCII_MAX) begin
				cp_acc   = ACC_W'(b);
				seq_kind = KIND_1B;
			end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
				cp_acc    = ACC_W'(b[4:0]);
				pend_cont = 2'd1;
				seq_kind  = KIND_2B;
			end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
				cp_acc    = ACC_W'(b[3:0]);
				pend_cont = 2'd2;
				seq_kind  = KIND_3B;
			end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
				cp_acc    = ACC_W'(b[2:0]);
				pend_cont = 2'd3;
				seq_kind  = KIND_4B;
			end else begin
				fault_seen = 1'b1;
			end
			return;
		end
		// bad continuation: flag it and parse the next byte as a lead
		if ((b & CONT_MASK) != CONT_TAG) begin
			fault_seen = 1'b1;
			pend_cont  = 2'd0;
			seq_kind   = KIND_1B;
			return;
		end
		cp_acc    = {cp_acc[ACC_W-7:0], b[5:0]};
		pend_cont = pend_cont - 2'd1;
		if (pend_cont == 2'd0) begin
			cp = cp_acc;
			// overlong 3/4-byte forms, surrogates, beyond the last code point
			if ((seq_kind == KIND_3B && cp < CP_MIN3) ||
			    (seq_kind == KIND_4B && cp < CP_MIN4) ||
			    (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ||
			    cp > CP_MAX)
				fault_seen = 1'b1;
			seq_kind = KIND_1B;
		end
	endfunction

	function automatic void judge_item(input in_t it);
		int unsigned lim;
		out_t        v;
		if (!it.empty_string)
			absorb_byte(it.data_byte);
		if (!it.end_of_string && !it.empty_string)
			return;
		lim = (limit_reg > ID_MAX) ? ID_MAX : limit_reg;
		v.id_valid    = !fault_seen && pend_cont == 2'd0 &&
		                byte_tally >= 1 && byte_tally <= lim;
		v.length_seen = LEN_W'(byte_tally);
		expected_verdicts = {expected_verdicts, v};
		pend_cont  = 2'd0;
		seq_kind   = KIND_1B;
		cp_acc     = '0;
		fault_seen = 1'b0;
		byte_tally = 0;
	endfunction

	// mostly short idles, now and then a long one
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic note_fault(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// Sender. valid stays up between back-to-back items; callers that stop
	// sending go through drain_results, which lowers it in the same step.
	// ------------------------------------------------------------------
	task automatic send_item(input in_t it);
		int gap;
		gap = tx_quiet ? 0 : idle_span();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		judge_item(it);
		items_sent++;
	endtask

	task automatic send_string(input byte_q_t s, input closing_t how);
		in_t it;
		foreach (s[i]) begin
			it.data_byte     = s[i];
			it.empty_string  = 1'b0;
			it.end_of_string = (how == END_ON_BYTE) && (i == s.size() - 1);
			send_item(it);
		end
		if (how != END_ON_BYTE || s.size() == 0) begin
			it.data_byte    = 8'($urandom_range(0, 255));
			it.empty_string = 1'b1;
			case (how)
				END_EMPTY_MARK: it.end_of_string = 1'b1;
				END_EMPTY_BARE: it.end_of_string = 1'b0;
				default:        it.end_of_string = 1'($urandom_range(0, 1));
			endcase
			send_item(it);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// register writes only with the pipe empty and the decoder settled
	task automatic set_max_length(input logic [CFG_W-1:0] v);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_reg = v;
	endtask

	function automatic void append_byte(ref byte_q_t q, input logic [7:0] b);
		q.insert(q.size(), b);
	endfunction

	// raw packing of a code point into n bytes, valid or not
	function automatic byte_q_t encode_char(input logic [ACC_W-1:0] cp, input int n);
		byte_q_t r;
		case (n)
			1: append_byte(r, {1'b0, cp[6:0]});
			2: begin
				append_byte(r, {3'b110, cp[10:6]});
				append_byte(r, {2'b10, cp[5:0]});
			end
			3: begin
				append_byte(r, {4'b1110, cp[15:12]});
				append_byte(r, {2'b10, cp[11:6]});
				append_byte(r, {2'b10, cp[5:0]});
			end
			default: begin
				append_byte(r, {5'b11110, cp[20:18]});
				append_byte(r, {2'b10, cp[17:12]});
				append_byte(r, {2'b10, cp[11:6]});
				append_byte(r, {2'b10, cp[5:0]});
			end
		endcase
		return r;
	endfunction

	function automatic byte_q_t random_char();
		int               r;
		int               n;
		logic [ACC_W-1:0] cp;
		byte_q_t          raw;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			n  = 1;
			cp = ACC_W'($urandom_range(0, 'h7f));
		end else if (r < 60) begin
			n  = 2;
			cp = ACC_W'($urandom_range('h80, 'h7ff));
		end else if (r < 78) begin
			n  = 3;
			cp = $urandom_range(0, 1) ? ACC_W'($urandom_range('h800, 'hd7ff))
			                          : ACC_W'($urandom_range('he000, 'hffff));
		end else if (r < 92) begin
			n  = 4;
			cp = ACC_W'($urandom_range('h10000, 'h10ffff));
		end else if (r < 95) begin
			// overlong: more bytes than the code point needs
			n  = $urandom_range(2, 4);
			cp = ACC_W'($urandom_range(0, (n == 2) ? 'h7f : (n == 3) ? 'h7ff : 'hffff));
		end else if (r < 97) begin
			n  = 3;
			cp = ACC_W'($urandom_range('hd800, 'hdfff));
		end else if (r < 99) begin
			n  = 4;
			cp = ACC_W'($urandom_range('h110000, 'h1fffff));
		end else begin
			append_byte(raw, 8'($urandom_range(0, 255)));
			return raw;
		end
		return encode_char(cp, n);
	endfunction

	// mostly well-formed strings; some truncated, corrupted or empty
	task automatic random_string();
		byte_q_t  s;
		int       nchars;
		int       r;
		closing_t how;
		nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		repeat (nchars) s = {s, random_char()};
		r = $urandom_range(0, 99);
		if (r < 8 && s.size() > 1)
			void'(s.pop_back());
		else if (r < 16)
			s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 3)
			s.delete();
		r = $urandom_range(0, 99);
		how = (r < 85) ? END_ON_BYTE : (r < 93) ? END_EMPTY_MARK : END_EMPTY_BARE;
		send_string(s, how);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_code_point_bounds();
		byte_q_t s;
		s = {8'h00, 8'h7f};               send_string(s, END_ON_BYTE);
		s = {8'hdf, 8'hbf};               send_string(s, END_ON_BYTE);
		s = {8'he0, 8'h9f, 8'hbf};        send_string(s, END_ON_BYTE); // overlong 3-byte
		s = {8'hed, 8'ha0, 8'h80};        send_string(s, END_ON_BYTE); // surrogate
		s = {8'hf0, 8'h8f, 8'hbf, 8'hbf}; send_string(s, END_ON_BYTE); // overlong 4-byte
		s = {8'hf4, 8'h90, 8'h80, 8'h80}; send_string(s, END_ON_BYTE); // above 10FFFF
	endtask

	task automatic test_malformed_input();
		byte_q_t s;
		// bad continuation, then the next byte parses as a lead
		s = {8'hc2, 8'h41, 8'h41}; send_string(s, END_ON_BYTE);
		s = {8'hff};               send_string(s, END_ON_BYTE);
		// sequence cut off by the end of the string
		s = {8'he2, 8'h82};        send_string(s, END_ON_BYTE);
	endtask

	task automatic test_empty_markers();
		byte_q_t s;
		send_string(s, END_EMPTY_BARE);   // no bytes at all
		s = {8'h61};
		send_string(s, END_EMPTY_MARK);   // marker ends a string with bytes
	endtask

	task automatic test_length_limit();
		byte_q_t s;
		set_max_length(9'd0);             // rejects everything
		s = {8'h61};        send_string(s, END_ON_BYTE);
		set_max_length(9'd1);
		s = {8'h61};        send_string(s, END_ON_BYTE);
		s = {8'h61, 8'h62}; send_string(s, END_ON_BYTE);
	endtask

	task automatic test_length_saturation();
		byte_q_t s;
		// above the parameter maximum acts as the maximum
		set_max_length(9'd511);
		repeat (ID_MAX / 2) s = {s, encode_char(ACC_W'($urandom_range('h80, 'h7ff)), 2)};
		send_string(s, END_ON_BYTE);
		s.delete();
		// byte count saturates one above the maximum
		repeat (ID_MAX + 2) append_byte(s, 8'($urandom_range(0, 'h7f)));
		send_string(s, END_ON_BYTE);
		set_max_length(MAX_LENGTH_RST);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		byte_q_t s;
		hold_off_req = 1'b1;
		tx_quiet     = 1'b1;
		repeat (24) begin
			s = {8'($urandom_range(0, 'h7f))};
			send_string(s, END_ON_BYTE);
		end
		tx_quiet = 1'b0;
	endtask

	task automatic test_random_strings();
		int               start;
		logic [CFG_W-1:0] lim;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       lim = CFG_W'($urandom_range(2, 20));
				1:       lim = 9'd0;
				2:       lim = CFG_W'($urandom_range(1, 8));
				3:       lim = 9'd511;
				4:       lim = CFG_W'($urandom_range(4, 24));
				default: lim = CFG_W'($urandom_range(1, ID_MAX));
			endcase
			set_max_length(lim);
			tx_quiet = (ph == 2);
			rx_quiet = (ph == 2 || ph == 4);
			start    = items_sent;
			while (items_sent < start + PHASE_ITEMS)
				random_string();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, quiet stretches, and one long hold-off
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready    <= 1'b1;
				hold_off_req = 1'b0;
			end else begin
				stall = rx_quiet ? 0 : idle_span();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	// each result transfer against the oldest expected verdict
	always @(posedge clk) begin : verdict_check
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				note_fault($sformatf("unexpected result: valid=%0b len=%0d",
				                     out_data.id_valid, out_data.length_seen));
			end else begin
				want = expected_verdicts.pop_front();
				if (out_data.id_valid !== want.id_valid ||
				    out_data.length_seen !== want.length_seen)
					note_fault($sformatf("mismatch: want valid=%0b len=%0d, got %0b len=%0d",
					                     want.id_valid, want.length_seen,
					                     out_data.id_valid, out_data.length_seen));
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("utf8_identifier_validator_core_test: FAIL");
		$finish;
	end

	initial begin : run
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_code_point_bounds();
		test_malformed_input();
		test_empty_markers();
		test_length_limit();
		test_length_saturation();
		test_output_backpressure();
		test_random_strings();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("utf8_identifier_validator_core_test: PASS");
		else
			$display("utf8_identifier_validator_core_test: FAIL");
		$finish;
	end

endmodule

@@ utf8_identifier_validator_core.f @@
design/uiv_pkg.sv
design/uiv_decode.sv
design/utf8_identifier_validator_core.sv
design/uiv_checker.sv
bench/utf8_identifier_validator_core_test.sv
